### hw/rtl/hsv_to_rgb_pixel_converter_macros.svh
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_MACROS_SVH

// Checked only while out of reset.
`define HTR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("htr assertion failed");

// Checked at every edge, reset included.
`define HTR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("htr assertion failed");

`endif

### hw/rtl/htr_pkg.sv
package htr_pkg;

  typedef enum logic [2:0] {
    SX_0    = 3'd0,
    SX_1    = 3'd1,
    SX_2    = 3'd2,
    SX_3    = 3'd3,
    SX_4    = 3'd4,
    SX_5    = 3'd5,
    SX_NONE = 3'd6
  } sextant_t;

  typedef enum logic [1:0] {
    CMP_ZERO   = 2'd0,
    CMP_CHROMA = 2'd1,
    CMP_X      = 2'd2
  } comp_sel_t;

  localparam int unsigned IN_W    = 32;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned CH_N    = 3;

  // t = floor(255*N / 2^16); q = floor(t / 60), saturates at 255*60
  localparam logic [13:0] T_CLAMP   = 14'd15300;
  // ceil(2^20 / 60), exact for t below 23831
  localparam logic [14:0] RECIP_60  = 15'd17477;

endpackage

### hw/rtl/hsv_to_rgb_pixel_converter.sv
// HSV to RGB pixel converter, five register stages.
// Throughput: one beat per cycle; each stage holds its beat while the next is full.
// Reset: synchronous active-low rst_n clears all stage valid bits; data is not reset.
module hsv_to_rgb_pixel_converter
  import htr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // hue_deg[8:0], saturation[17:9], brightness[26:18]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic [8:0] hue, sat, val;
  assign hue = in_tdata[8:0];
  assign sat = in_tdata[17:9];
  assign val = in_tdata[26:18];

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // stage 1: chroma product, hue weight, sextant
  logic [6:0] hmod;
  logic [5:0] hdist, wgt;
  sextant_t   sx;

  always_comb begin
    if (hue < 9'd120)      hmod = hue[6:0];
    else if (hue < 9'd240) hmod = 7'(hue - 9'd120);
    else if (hue < 9'd360) hmod = 7'(hue - 9'd240);
    else if (hue < 9'd480) hmod = 7'(hue - 9'd360);
    else                   hmod = 7'(hue - 9'd480);
    if (hmod >= 7'd60) hdist = 6'(hmod - 7'd60);
    else               hdist = 6'(7'd60 - hmod);
    wgt = 6'd60 - hdist;
    if (hue <= 9'd60)       sx = SX_0;
    else if (hue <= 9'd120) sx = SX_1;
    else if (hue <= 9'd180) sx = SX_2;
    else if (hue <= 9'd240) sx = SX_3;
    else if (hue <= 9'd300) sx = SX_4;
    else if (hue <= 9'd360) sx = SX_5;
    else                    sx = SX_NONE;
  end

  logic [17:0] vs1_r;
  logic [5:0]  wgt1_r;
  logic [8:0]  val1_r;
  sextant_t    sx1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      vs1_r  <= val * sat;
      wgt1_r <= wgt;
      val1_r <= val;
      sx1_r  <= sx;
    end
  end

  // stage 2: scaled offset, X term, full-chroma term (all in 1/(65536*60))
  logic signed [18:0] m0;
  logic signed [24:0] m0x;
  assign m0  = $signed({2'b00, val1_r, 8'h00}) - $signed({1'b0, vs1_r});
  assign m0x = 25'(m0);

  logic signed [24:0] a2_r;
  logic [23:0]        xn2_r;
  logic [22:0]        vh2_r;
  sextant_t           sx2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      a2_r  <= (m0x <<< 6) - (m0x <<< 2);
      xn2_r <= vs1_r * wgt1_r;
      vh2_r <= (23'(val1_r) << 14) - (23'(val1_r) << 10);
      sx2_r <= sx1_r;
    end
  end

  // stage 3: per-channel numerator
  comp_sel_t csel [CH_N];

  always_comb begin
    csel[0] = CMP_ZERO;
    csel[1] = CMP_ZERO;
    csel[2] = CMP_ZERO;
    case (sx2_r)
      SX_0: begin csel[0] = CMP_CHROMA; csel[1] = CMP_X;      end
      SX_1: begin csel[0] = CMP_X;      csel[1] = CMP_CHROMA; end
      SX_2: begin csel[1] = CMP_CHROMA; csel[2] = CMP_X;      end
      SX_3: begin csel[1] = CMP_X;      csel[2] = CMP_CHROMA; end
      SX_4: begin csel[0] = CMP_X;      csel[2] = CMP_CHROMA; end
      SX_5: begin csel[0] = CMP_CHROMA; csel[2] = CMP_X;      end
      default: begin end
    endcase
  end

  logic signed [25:0] n3_r [CH_N];
  logic [13:0]        t4_r [CH_N];
  logic [7:0]         q5_r [CH_N];

  for (genvar c = 0; c < CH_N; c++) begin : g_ch
    logic signed [25:0] n_sum;
    logic [32:0]        p;
    logic [16:0]        t;
    logic [28:0]        qp;

    always_comb begin
      case (csel[c])
        CMP_CHROMA: n_sum = $signed({3'b000, vh2_r});
        CMP_X:      n_sum = 26'(a2_r) + $signed({2'b00, xn2_r});
        default:    n_sum = 26'(a2_r);
      endcase
    end

    always_ff @(posedge clk) begin
      if (en3) n3_r[c] <= n_sum;
    end

    // stage 4: 255*N >> 16, negative or zero gives zero, saturate
    assign p = {n3_r[c][24:0], 8'h00} - {8'h00, n3_r[c][24:0]};
    assign t = p[32:16];

    always_ff @(posedge clk) begin
      if (en4) begin
        if (n3_r[c] <= 26'sd0)          t4_r[c] <= '0;
        else if (t > 17'(T_CLAMP))      t4_r[c] <= T_CLAMP;
        else                            t4_r[c] <= t[13:0];
      end
    end

    // stage 5: divide by 60
    assign qp = t4_r[c] * RECIP_60;

    always_ff @(posedge clk) begin
      if (en5) q5_r[c] <= qp[27:20];
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {q5_r[2], q5_r[1], q5_r[0]};

endmodule

### hw/rtl/htr_checker.sv
`include "hsv_to_rgb_pixel_converter_macros.svh"

module htr_checker
  import htr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  `HTR_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `HTR_ASSERT(a_ready_flow, clk, rst_n, out_tready |-> in_tready)
  `HTR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)
  `HTR_ASSERT(a_idle_ready, clk, rst_n, !out_tvalid |-> in_tready)

endmodule

bind hsv_to_rgb_pixel_converter htr_checker u_htr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
